// ===== hw/rtl/ambient_light_lux_autogain_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef AMBIENT_LIGHT_LUX_AUTOGAIN_MACROS_SVH
`define AMBIENT_LIGHT_LUX_AUTOGAIN_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ALLA_ASSERT_IMPL(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define ALLA_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`else
`define ALLA_ASSERT_IMPL(label, clk, rst, pre, post, msg)
`define ALLA_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== hw/rtl/alla_pkg.sv =====
package alla_pkg;

   // field widths
   localparam int RAW_W   = 16;
   localparam int LUX_W   = 48;
   localparam int GAIN_W  = 2;
   localparam int ITIME_W = 3;
   localparam int SHIFT_W = 4;

   // configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEGRATION_TIME = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_GAIN       = 1'b1;

   // gain steps
   localparam logic [GAIN_W-1:0] GAIN_EIGHTH  = 2'd0;
   localparam logic [GAIN_W-1:0] GAIN_QUARTER = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_ONE     = 2'd2;
   localparam logic [GAIN_W-1:0] GAIN_TWO     = 2'd3;

   // scaled count: raw * 21, divided by 625 after a shift of 13 + s
   localparam int SCALED_W  = 21;
   localparam int PRESHIFT  = 13;
   localparam int DIVISOR   = 625;
   localparam int DIV_REM_W = 10;
   localparam int CNT_W     = 6;

   // serial multiplier datapath
   localparam int X_W   = 34;
   localparam int A_W   = 30;
   localparam int HI_W  = A_W + 1;
   localparam int P16_W = HI_W + X_W - 16;

   // polynomial coefficients
   localparam logic signed [A_W-1:0]   K_C4 = 30'sd44371798;
   localparam logic signed [A_W-1:0]   K_C3 = -30'sd10574902;
   localparam logic signed [A_W-1:0]   K_C2 = 30'sd349988;
   localparam logic signed [P16_W-1:0] K_C1 = 49'sd4304845721;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MUL_T1,
      ST_MUL_T2,
      ST_MUL_T3,
      ST_MUL_Y,
      ST_FINISH
   } state_type;

   // log2 of the gain factor relative to gain two
   function automatic logic [SHIFT_W-1:0] gain_shift(input logic [GAIN_W-1:0] g);
      logic [SHIFT_W-1:0] s;
      unique case (g)
         GAIN_EIGHTH:  s = 4'd4;
         GAIN_QUARTER: s = 4'd3;
         GAIN_ONE:     s = 4'd1;
         GAIN_TWO:     s = 4'd0;
         default:      s = 4'd0;
      endcase
      return s;
   endfunction

endpackage

// ===== hw/rtl/alla_div.sv =====
module alla_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [alla_pkg::RAW_W-1:0]          raw,
   input  logic [alla_pkg::SHIFT_W-1:0]        shift,
   output logic                                done,
   output logic [alla_pkg::X_W-1:0]            quotient
);

   localparam int TRIAL_W = alla_pkg::DIV_REM_W + 1;

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [alla_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic [alla_pkg::SCALED_W-1:0]     num_ff, num_in;
   logic [alla_pkg::DIV_REM_W-1:0]    rem_ff, rem_in;
   logic [alla_pkg::X_W-1:0]          quo_ff, quo_in;
   logic [alla_pkg::SCALED_W-1:0]     scaled;
   logic [TRIAL_W-1:0]                trial;
   logic                              q_bit;

   // raw * 21 as shift-adds
   assign scaled = (alla_pkg::SCALED_W'(raw) << 4) + (alla_pkg::SCALED_W'(raw) << 2)
                 + alla_pkg::SCALED_W'(raw);

   // one quotient bit per cycle, trailing zeros of the shift fed in after the count
   assign trial = {rem_ff, num_ff[alla_pkg::SCALED_W-1]};
   assign q_bit = (trial >= TRIAL_W'(alla_pkg::DIVISOR));

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = alla_pkg::CNT_W'(alla_pkg::SCALED_W + alla_pkg::PRESHIFT)
                 + alla_pkg::CNT_W'(shift);
         num_in  = scaled;
         rem_in  = '0;
         quo_in  = '0;
      end else if (busy_ff) begin
         num_in = {num_ff[alla_pkg::SCALED_W-2:0], 1'b0};
         rem_in = q_bit ? alla_pkg::DIV_REM_W'(trial - TRIAL_W'(alla_pkg::DIVISOR))
                        : trial[alla_pkg::DIV_REM_W-1:0];
         quo_in = {quo_ff[alla_pkg::X_W-2:0], q_bit};
         cnt_in = cnt_ff - alla_pkg::CNT_W'(1);
         if (cnt_ff == alla_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hw/rtl/alla_mul.sv =====
module alla_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [alla_pkg::A_W-1:0]   a,
   input  logic [alla_pkg::X_W-1:0]          x,
   output logic                              done,
   output logic signed [alla_pkg::HI_W-1:0]  prod_hi,
   output logic [alla_pkg::X_W-1:0]          prod_lo
);

   logic                              busy_ff, busy_in;
   logic                              done_ff, done_in;
   logic [alla_pkg::CNT_W-1:0]        cnt_ff, cnt_in;
   logic signed [alla_pkg::A_W-1:0]   a_ff, a_in;
   logic signed [alla_pkg::HI_W-1:0]  hi_ff, hi_in;
   logic [alla_pkg::X_W-1:0]          lo_ff, lo_in;
   logic signed [alla_pkg::HI_W-1:0]  sum;

   // add the multiplicand when the current multiplier bit is set
   assign sum = lo_ff[0] ? (hi_ff + alla_pkg::HI_W'(a_ff)) : hi_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = alla_pkg::CNT_W'(alla_pkg::X_W);
         a_in    = a;
         hi_in   = '0;
         lo_in   = x;
      end else if (busy_ff) begin
         // arithmetic shift of the whole product one place right
         hi_in  = {sum[alla_pkg::HI_W-1], sum[alla_pkg::HI_W-1:1]};
         lo_in  = {sum[0], lo_ff[alla_pkg::X_W-1:1]};
         cnt_in = cnt_ff - alla_pkg::CNT_W'(1);
         if (cnt_ff == alla_pkg::CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      a_ff  <= a_in;
      hi_ff <= hi_in;
      lo_ff <= lo_in;
   end

   assign done    = done_ff;
   assign prod_hi = hi_ff;
   assign prod_lo = lo_ff;

endmodule

// ===== hw/rtl/ambient_light_lux_autogain.sv =====
// flow: an accepted word goes through the divider, then the multiplier, then the output
// register to rsp_valid; s = shift of 0 to 9 (set by integration time and gain)
// a new word is taken only once the result is loaded; the work is the bit-serial divide by 625
// (34 + s steps) and four 34-step serial multiplies of the polynomial
// reset: synchronous; integration time 100 ms, gain 1/8, no result pending
`include "ambient_light_lux_autogain_macros.svh"

module ambient_light_lux_autogain (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [alla_pkg::RAW_W-1:0]           req_raw_count,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [alla_pkg::LUX_W-1:0]           rsp_lux_value,
   output logic [alla_pkg::GAIN_W-1:0]          rsp_gain_used,
   output logic [alla_pkg::GAIN_W-1:0]          rsp_next_gain,
   output logic                                 rsp_out_of_range,
   output logic                                 rsp_gain_changed,
   input  logic                                 csr_wr_en,
   input  logic [alla_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [alla_pkg::CSR_DATA_W-1:0]      csr_wr_data
);

   localparam logic [alla_pkg::RAW_W-1:0]   HIGH_LIMIT  = 16'd10000;
   localparam logic [alla_pkg::RAW_W-1:0]   LOW_LIMIT   = 16'd100;
   localparam logic [alla_pkg::ITIME_W-1:0] ITIME_MAX   = 3'd5;
   localparam logic [alla_pkg::ITIME_W-1:0] ITIME_RESET = 3'd2;
   localparam logic [alla_pkg::ITIME_W-1:0] T_FALLBACK  = 3'd3;

   alla_pkg::state_type                 state_ff, state_in;
   logic [alla_pkg::ITIME_W-1:0]        itime_ff;
   logic [alla_pkg::GAIN_W-1:0]         gain_ff;
   logic [alla_pkg::X_W-1:0]            x_ff;
   logic [alla_pkg::GAIN_W-1:0]         used_ff, next_ff;
   logic                                oor_ff;
   logic                                rsp_valid_ff;
   logic [alla_pkg::LUX_W-1:0]          lux_ff;
   logic [alla_pkg::GAIN_W-1:0]         rsp_used_ff, rsp_next_ff;
   logic                                rsp_oor_ff, rsp_changed_ff;

   logic                                accept;
   logic                                out_free;
   logic                                load_rsp;
   logic                                above, below;
   logic [alla_pkg::GAIN_W-1:0]         gain_next;
   logic [alla_pkg::ITIME_W-1:0]        t_shift;
   logic [alla_pkg::SHIFT_W-1:0]        shift;

   logic                                div_done;
   logic [alla_pkg::X_W-1:0]            div_quotient;
   logic                                mul_start, mul_done;
   logic signed [alla_pkg::A_W-1:0]     mul_a;
   logic [alla_pkg::X_W-1:0]            mul_x;
   logic signed [alla_pkg::HI_W-1:0]    mul_hi;
   logic [alla_pkg::X_W-1:0]            mul_lo;

   logic signed [alla_pkg::HI_W+1:0]    p32;
   logic signed [alla_pkg::HI_W+1:0]    t1_wide;
   logic signed [alla_pkg::HI_W-1:0]    t2_wide;
   logic signed [alla_pkg::P16_W-1:0]   p16;
   logic signed [alla_pkg::P16_W-1:0]   t3_wide;
   logic signed [alla_pkg::A_W-1:0]     t1, t2, t3_scaled;
   logic [alla_pkg::LUX_W-1:0]          lux;

   // handshake
   assign accept    = req_valid && (state_ff == alla_pkg::ST_IDLE);
   assign req_stall = (state_ff != alla_pkg::ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // gain decision for the following sample
   assign above = (req_raw_count > HIGH_LIMIT);
   assign below = (req_raw_count < LOW_LIMIT);

   always_comb begin
      gain_next = gain_ff;
      priority if (above) begin
         if (gain_ff != alla_pkg::GAIN_EIGHTH) gain_next = gain_ff - alla_pkg::GAIN_W'(1);
      end else if (below) begin
         if (gain_ff != alla_pkg::GAIN_TWO) gain_next = gain_ff + alla_pkg::GAIN_W'(1);
      end else begin
         gain_next = gain_ff;
      end
   end

   // combined shift from integration time and gain, undefined codes run as 100 ms
   assign t_shift = (itime_ff <= ITIME_MAX) ? (ITIME_MAX - itime_ff) : T_FALLBACK;
   assign shift   = alla_pkg::SHIFT_W'(t_shift) + alla_pkg::gain_shift(gain_ff);

   // configuration and gain state
   always_ff @(posedge clock) begin
      if (reset) begin
         itime_ff <= ITIME_RESET;
         gain_ff  <= alla_pkg::GAIN_EIGHTH;
      end else begin
         priority if (csr_wr_en) begin
            unique case (csr_index)
               alla_pkg::CSR_INTEGRATION_TIME: itime_ff <= csr_wr_data;
               alla_pkg::CSR_START_GAIN:       gain_ff  <= csr_wr_data[alla_pkg::GAIN_W-1:0];
               default: ;
            endcase
         end else if (accept) begin
            gain_ff <= gain_next;
         end else begin
            gain_ff <= gain_ff;
         end
      end
   end

   // per-word side fields
   always_ff @(posedge clock) begin
      if (accept) begin
         used_ff <= gain_ff;
         next_ff <= gain_next;
         oor_ff  <= above || below;
      end
      if (div_done) begin
         x_ff <= div_quotient;
      end
   end

   // serial units
   alla_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (accept),
      .raw      (req_raw_count),
      .shift    (shift),
      .done     (div_done),
      .quotient (div_quotient)
   );

   alla_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .x       (mul_x),
      .done    (mul_done),
      .prod_hi (mul_hi),
      .prod_lo (mul_lo)
   );

   // horner terms from the finished product
   assign p32       = {mul_hi, mul_lo[alla_pkg::X_W-1:alla_pkg::X_W-2]};
   assign t1_wide   = p32 + (alla_pkg::HI_W+2)'(alla_pkg::K_C3);
   assign t1        = t1_wide[alla_pkg::A_W-1:0];
   assign t2_wide   = mul_hi + alla_pkg::HI_W'(alla_pkg::K_C2);
   assign t2        = t2_wide[alla_pkg::A_W-1:0];
   assign p16       = {mul_hi, mul_lo[alla_pkg::X_W-1:16]};
   assign t3_wide   = p16 + alla_pkg::K_C1;
   assign t3_scaled = t3_wide[alla_pkg::A_W+15:16];
   assign lux       = p16[alla_pkg::P16_W-1] ? '0 : p16[alla_pkg::LUX_W-1:0];

   assign mul_x = (state_ff == alla_pkg::ST_DIVIDE) ? div_quotient : x_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         alla_pkg::ST_IDLE:   if (accept)   state_in = alla_pkg::ST_DIVIDE;
         alla_pkg::ST_DIVIDE: if (div_done) state_in = alla_pkg::ST_MUL_T1;
         alla_pkg::ST_MUL_T1: if (mul_done) state_in = alla_pkg::ST_MUL_T2;
         alla_pkg::ST_MUL_T2: if (mul_done) state_in = alla_pkg::ST_MUL_T3;
         alla_pkg::ST_MUL_T3: if (mul_done) state_in = alla_pkg::ST_MUL_Y;
         alla_pkg::ST_MUL_Y:  if (mul_done) state_in = alla_pkg::ST_FINISH;
         alla_pkg::ST_FINISH: if (out_free) state_in = alla_pkg::ST_IDLE;
         default:                           state_in = alla_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      mul_start = 1'b0;
      mul_a     = alla_pkg::K_C4;
      load_rsp  = 1'b0;
      unique case (state_ff)
         alla_pkg::ST_IDLE: ;
         alla_pkg::ST_DIVIDE: begin
            mul_start = div_done;
            mul_a     = alla_pkg::K_C4;
         end
         alla_pkg::ST_MUL_T1: begin
            mul_start = mul_done;
            mul_a     = t1;
         end
         alla_pkg::ST_MUL_T2: begin
            mul_start = mul_done;
            mul_a     = t2;
         end
         alla_pkg::ST_MUL_T3: begin
            mul_start = mul_done;
            mul_a     = t3_scaled;
         end
         alla_pkg::ST_MUL_Y: ;
         alla_pkg::ST_FINISH: load_rsp = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alla_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         lux_ff         <= lux;
         rsp_used_ff    <= used_ff;
         rsp_next_ff    <= next_ff;
         rsp_oor_ff     <= oor_ff;
         rsp_changed_ff <= (next_ff != used_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_lux_value    = lux_ff;
   assign rsp_gain_used    = rsp_used_ff;
   assign rsp_next_gain    = rsp_next_ff;
   assign rsp_out_of_range = rsp_oor_ff;
   assign rsp_gain_changed = rsp_changed_ff;

   // checks
   `ALLA_ASSERT_IMPL(a_changed_match, clock, reset, rsp_valid, rsp_gain_changed == (rsp_next_gain != rsp_gain_used), "gain_changed disagrees with gain fields")
   `ALLA_ASSERT_IMPL(a_in_range_keeps, clock, reset, rsp_valid && !rsp_out_of_range, !rsp_gain_changed, "gain moved on an in-range count")
   `ALLA_ASSERT_IMPL(a_div_done_state, clock, reset, div_done, state_ff == alla_pkg::ST_DIVIDE, "divider finished outside divide state")
   `ALLA_ASSERT_IMPL(a_mul_done_state, clock, reset, mul_done, (state_ff == alla_pkg::ST_MUL_T1) || (state_ff == alla_pkg::ST_MUL_T2) || (state_ff == alla_pkg::ST_MUL_T3) || (state_ff == alla_pkg::ST_MUL_Y), "multiplier finished outside multiply states")
   `ALLA_ASSERT_NEXT(a_mul_no_early, clock, reset, mul_start, !mul_done, "multiplier finished right after start")

endmodule

// ===== bench/ambient_light_lux_autogain_test.sv =====
module ambient_light_lux_autogain_test;
   import alla_pkg::*;

   // light thresholds and run shape
   localparam int unsigned HIGH_COUNT = 10000;
   localparam int unsigned LOW_COUNT  = 100;
   localparam int BATCHES      = 32;
   localparam int BATCH_WORDS  = 51;
   localparam int LONG_HOLD    = 1200;
   localparam int SETTLE       = 200;

   // polynomial coefficients of the correction curve
   localparam longint LUX_C4 = 44371798;
   localparam longint LUX_C3 = -10574902;
   localparam longint LUX_C2 = 349988;
   localparam longint LUX_C1 = 64'sd4304845721;
   localparam logic signed [127:0] LUX_TOP = {80'd0, {LUX_W{1'b1}}};

   typedef struct packed {
      logic [LUX_W-1:0]  lux;
      logic [GAIN_W-1:0] gain_used;
      logic [GAIN_W-1:0] next_gain;
      logic              oor;
      logic              changed;
   } lux_word_type;

   // expected conversions, in order of acceptance
   class lux_scoreboard;
      logic [ITIME_W-1:0] itime;
      logic [GAIN_W-1:0]  gain;
      lux_word_type       awaited_lux[$];
      int                 mismatches;
      int                 checked;
      int                 samples;
      int                 reg_writes;

      function new();
         itime = 3'd2;
         gain = GAIN_EIGHTH;
         mismatches = 0;
         checked = 0;
         samples = 0;
         reg_writes = 0;
      endfunction

      function void note_config(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         reg_writes++;
         if (idx == CSR_INTEGRATION_TIME) begin
            itime = data;
         end else if (idx == CSR_START_GAIN) begin
            gain = data[GAIN_W-1:0];
         end
      endfunction

      // lux in Q16 for one raw count at the current gain and integration time
      function logic [LUX_W-1:0] lux_of(logic [RAW_W-1:0] raw);
         logic signed [127:0] scaled, xq, t1, t2, t3, y;
         int unsigned shift;
         shift = (itime <= 3'd5) ? 5 - itime : 3;
         case (gain)
            GAIN_EIGHTH:  shift += 4;
            GAIN_QUARTER: shift += 3;
            GAIN_ONE:     shift += 1;
            default:      shift += 0;
         endcase
         scaled = {112'd0, raw};
         xq = ((scaled * 21) <<< (shift + 16)) / 5000;
         t1 = ((LUX_C4 * xq) >>> 32) + LUX_C3;
         t2 = ((t1 * xq) >>> 34) + LUX_C2;
         t3 = ((t2 * xq) >>> 16) + LUX_C1;
         y = ((t3 >>> 16) * xq) >>> 16;
         if (y < 0) y = 0;
         if (y > LUX_TOP) y = LUX_TOP;
         return y[LUX_W-1:0];
      endfunction

      function void note_sample(logic [RAW_W-1:0] raw);
         lux_word_type w;
         w.gain_used = gain;
         w.next_gain = gain;
         w.oor = 1'b0;
         w.lux = lux_of(raw);
         if (raw > HIGH_COUNT) begin
            w.oor = 1'b1;
            if (gain != GAIN_EIGHTH) w.next_gain = gain - GAIN_W'(1);
         end else if (raw < LOW_COUNT) begin
            w.oor = 1'b1;
            if (gain != GAIN_TWO) w.next_gain = gain + GAIN_W'(1);
         end
         w.changed = (w.next_gain != w.gain_used);
         gain = w.next_gain;
         awaited_lux.push_back(w);
         samples++;
      endfunction

      function void check_result(lux_word_type got);
         lux_word_type want;
         if (awaited_lux.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: result word with nothing pending, lux %h", $time, got.lux);
            return;
         end
         want = awaited_lux.pop_front();
         checked++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
               $write("%0t: expected/actual lux %h/%h gain_used %0d/%0d next_gain %0d/%0d",
                      $time, want.lux, got.lux, want.gain_used, got.gain_used,
                      want.next_gain, got.next_gain);
               $display(" out_of_range %0b/%0b gain_changed %0b/%0b",
                        want.oor, got.oor, want.changed, got.changed);
            end
         end
      endfunction

      function int pending();
         return awaited_lux.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [RAW_W-1:0]      req_raw_count;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [LUX_W-1:0]      rsp_lux_value;
   logic [GAIN_W-1:0]     rsp_gain_used;
   logic [GAIN_W-1:0]     rsp_next_gain;
   logic                  rsp_out_of_range;
   logic                  rsp_gain_changed;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   lux_scoreboard sb = new();
   lux_word_type  seen_word;
   int            sender_idle_pct = 0;
   int            rsp_stall_pct = 0;
   logic          hold_request = 1'b0;

   ambient_light_lux_autogain u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_raw_count    (req_raw_count),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_lux_value    (rsp_lux_value),
      .rsp_gain_used    (rsp_gain_used),
      .rsp_next_gain    (rsp_next_gain),
      .rsp_out_of_range (rsp_out_of_range),
      .rsp_gain_changed (rsp_gain_changed),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watch both channels and the register port
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wr_en) sb.note_config(csr_index, csr_wr_data);
         if (rsp_valid && !rsp_stall) begin
            seen_word.lux = rsp_lux_value;
            seen_word.gain_used = rsp_gain_used;
            seen_word.next_gain = rsp_next_gain;
            seen_word.oor = rsp_out_of_range;
            seen_word.changed = rsp_gain_changed;
            sb.check_result(seen_word);
         end
         if (req_valid && !req_stall) sb.note_sample(req_raw_count);
      end
   end

   // receiver: random stalls, or one long hold-off on request
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // offer one word, after a random gap, and wait until it is taken
   task automatic send_word(input logic [RAW_W-1:0] raw);
      int gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct) gap++;
      if (sender_idle_pct != 0 && $urandom_range(9) == 0) gap += $urandom_range(250, 1);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_raw_count <= raw;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait for every pending result
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      drain_results();
      repeat (2) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly counts near and past the gain-switch thresholds
   function automatic logic [RAW_W-1:0] pick_count();
      case ($urandom_range(9))
         0, 1, 2: return RAW_W'($urandom_range(LOW_COUNT - 1));
         3, 4:    return RAW_W'($urandom_range(65535, HIGH_COUNT + 1));
         5: begin
            case ($urandom_range(7))
               0: return 16'd0;
               1: return RAW_W'(LOW_COUNT - 1);
               2: return RAW_W'(LOW_COUNT);
               3: return RAW_W'(LOW_COUNT + 1);
               4: return RAW_W'(HIGH_COUNT - 1);
               5: return RAW_W'(HIGH_COUNT);
               6: return RAW_W'(HIGH_COUNT + 1);
               default: return 16'hFFFF;
            endcase
         end
         6: return RAW_W'($urandom_range(65535));
         default: return RAW_W'($urandom_range(HIGH_COUNT, LOW_COUNT));
      endcase
   endfunction

   initial begin : stimulus
      logic [RAW_W-1:0] boundary_words[12];
      int sender_pct[4];
      int receiver_pct[4];
      boundary_words = '{16'd0, 16'd99, 16'd100, 16'd10000, 16'd0, 16'd0,
                         16'd65535, 16'd10001, 16'd10000, 16'd65535, 16'd65535, 16'd1};
      sender_pct = '{0, 56, 0, 10};
      receiver_pct = '{0, 0, 56, 10};

      reset <= 1'b1;
      req_valid <= 1'b0;
      req_raw_count <= '0;
      rsp_stall <= 1'b0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_INTEGRATION_TIME;
      csr_wr_data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: walk the gain up to its top, then down past its bottom
      foreach (boundary_words[i]) send_word(boundary_words[i]);

      // shortest integration time at lowest gain gives the largest linear lux
      write_reg(CSR_INTEGRATION_TIME, 3'd0);
      write_reg(CSR_START_GAIN, CSR_DATA_W'(GAIN_EIGHTH));
      send_word(16'hFFFF);
      // longest integration time at highest gain
      write_reg(CSR_INTEGRATION_TIME, 3'd5);
      write_reg(CSR_START_GAIN, CSR_DATA_W'(GAIN_TWO));
      send_word(16'h0000);
      send_word(16'hFFFF);
      send_word(16'hAAAA);
      // undefined integration codes fall back to 100 ms
      write_reg(CSR_INTEGRATION_TIME, 3'd6);
      send_word(16'd12345);
      write_reg(CSR_INTEGRATION_TIME, 3'd7);
      send_word(16'd54321);
      // upper data bit is ignored by the gain register
      write_reg(CSR_START_GAIN, {1'b1, GAIN_ONE});
      send_word(16'd5000);

      // random batches, each with its own register settings and idling pattern
      for (int b = 0; b < BATCHES; b++) begin
         write_reg(CSR_INTEGRATION_TIME, CSR_DATA_W'($urandom_range(7)));
         if ($urandom_range(1) == 0 || b < 2)
            write_reg(CSR_START_GAIN, CSR_DATA_W'($urandom_range(7)));
         sender_idle_pct = sender_pct[b % 4];
         rsp_stall_pct = receiver_pct[b % 4];
         for (int i = 0; i < BATCH_WORDS; i++) begin
            if (b == 4 && i == 10) hold_request = 1'b1;
            if (b == 4 && i == 30) drain_results();
            send_word(pick_count());
         end
      end

      drain_results();
      repeat (SETTLE) @(posedge clock);
      $display("%0d words converted over %0d register writes, all integration codes and gain steps",
               sb.samples, sb.reg_writes);
      $display("%0d results checked with four idling patterns and a long output hold-off",
               sb.checked);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : watchdog
      #40000000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
